// ----- hw/rtl/ola_pkg.sv -----
// Shared constants, codes and types for the ordered list block.
package ola_pkg;

	// List geometry
	localparam int DEPTH      = 16;
	localparam int RESULT_CAP = 16;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int DATA_W     = 32;

	// Opcodes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// Per-cell update select: load operand, take neighbour, or take head (wrap)
	typedef struct packed {
		logic load;
		logic shift;
		logic wrap;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/ola_cell.sv -----
// One list slot: holds an entry, compares it to the operand, moves data along the row.
module ola_cell
	import ola_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] next_data,
	input  logic signed [DATA_W-1:0] head_data,
	output logic signed [DATA_W-1:0] data,
	output logic                     eq
);

	logic signed [DATA_W-1:0] data_q;

	// slot update: append load, close gap / rotate from neighbour, wrap from head
	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			data_q <= value;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end else if (ctl.wrap) begin
			data_q <= head_data;
		end
	end

	assign data = data_q;
	assign eq   = (data_q == value);

endmodule

// ----- hw/rtl/ordered_list_append_remove.sv -----
// Top level of the ordered list: control, count and a row of list cells.
//
// Usage: a command beat is taken on a rising edge with start high and busy
// low; it carries opcode and value. Results appear on item, entry_count,
// status and last for exactly one cycle with valid high; the receiver cannot
// stall, so every result must be taken when shown.
// For append and remove, the result shows in the cycle
// after the command, and busy stays low, so such commands may be issued in
// every cycle. All cells compare against the operand in parallel; the first
// match and every later cell take their neighbour's entry, closing the gap.
// Dump of an empty list answers in the cycle after the command with status
// empty, and busy stays low. Dump of N entries raises busy after the command
// while the row rotates toward the head once per cycle; the head cell is
// emitted each cycle, so the N results come out one per cycle, with last
// set on the final one, and the next command is taken once busy drops.
// Opcode 3 is ignored and gives no result.
// Reset (arst_n low) empties the list and drops any dump in progress; the
// slot contents are not cleared, as only occupied slots are ever read.
module ordered_list_append_remove
	import ola_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] value,
	output logic                     valid,
	output logic signed [DATA_W-1:0] item,
	output logic [4:0]               entry_count,
	output logic [1:0]               status,
	output logic                     last
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic                     state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         dcnt_q;
	logic                     valid_q;
	logic signed [DATA_W-1:0] item_q;
	logic [1:0]               status_q;
	logic                     last_q;

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]         eq;
	logic [DEPTH-1:0]         occ;
	logic [DEPTH-1:0]         hit;
	logic [DEPTH-1:0]         seen;
	cell_ctl_t                ctl [DEPTH];

	logic             accept;
	logic             full;
	logic             found;
	logic [CNT_W-1:0] ncap;

	assign accept = start && (state_q == S_IDLE);
	assign full   = (count_q >= CNT_W'(DEPTH));
	assign found  = |hit;
	assign ncap   = (count_q > CNT_W'(RESULT_CAP)) ? CNT_W'(RESULT_CAP) : count_q;

	// row of cells with per-slot match detection
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] nxt;

		if (i == DEPTH - 1) begin : g_end
			assign nxt = cell_data[i];
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end

		assign occ[i]  = (CNT_W'(i) < count_q);
		assign hit[i]  = eq[i] && occ[i];
		// first match at or before this slot
		assign seen[i] = |(hit & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));

		// slot control
		always_comb begin
			ctl[i] = '0;
			if (accept && (opcode == OP_APPEND) && !full) begin
				ctl[i].load = (CNT_W'(i) == count_q);
			end else if (accept && (opcode == OP_REMOVE)) begin
				ctl[i].shift = seen[i];
			end else if (state_q == S_DUMP) begin
				ctl[i].shift = (CNT_W'(i + 1) < count_q);
				ctl[i].wrap  = (CNT_W'(i + 1) == count_q);
			end
		end

		ola_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.value     (value),
			.next_data (nxt),
			.head_data (cell_data[0]),
			.data      (cell_data[i]),
			.eq        (eq[i])
		);
	end

	// control, count and dump sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			dcnt_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (opcode)
							OP_APPEND: begin
								valid_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_REMOVE: begin
								valid_q <= 1'b1;
								if (found) begin
									count_q <= count_q - CNT_W'(1);
								end
							end
							OP_DUMP: begin
								// only an empty list answers here
								valid_q <= (count_q == '0);
								dcnt_q  <= '0;
								if (count_q != '0) begin
									state_q <= S_DUMP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DUMP: begin
					valid_q <= (dcnt_q < ncap);
					dcnt_q  <= dcnt_q + CNT_W'(1);
					if (dcnt_q == count_q - CNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				last_q <= 1'b1;
				unique case (opcode)
					OP_APPEND: begin
						item_q   <= value;
						status_q <= full ? ST_FULL : ST_OK;
					end
					OP_REMOVE: begin
						item_q   <= value;
						status_q <= found ? ST_OK : ST_NOT_FOUND;
					end
					OP_DUMP: begin
						item_q   <= '0;
						status_q <= ST_EMPTY;
					end
					default: begin
						item_q   <= value;
						status_q <= ST_OK;
					end
				endcase
			end
			S_DUMP: begin
				item_q   <= cell_data[0];
				status_q <= ST_OK;
				last_q   <= (dcnt_q == ncap - CNT_W'(1));
			end
			default: begin
				item_q <= value;
			end
		endcase
	end

	assign busy        = (state_q == S_DUMP);
	assign valid       = valid_q;
	assign item        = item_q;
	assign entry_count = 5'(count_q);
	assign status      = status_q;
	assign last        = last_q;

endmodule

// ----- test/tb.sv -----
// Testbench for the ordered list block: directed and random command beats checked against a behavioural list.
`timescale 1ns / 1ps
module tb;
	import ola_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;	// spare opcode, the block ignores it
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BEATS = 260;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic signed [DATA_W-1:0] item;
		logic [4:0]               entry_count;
		logic [1:0]               status;
		logic                     last;
	} list_result_t;

	logic                     clk    = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start  = 1'b0;
	logic [1:0]               opcode = OP_APPEND;
	logic signed [DATA_W-1:0] value  = '0;
	logic                     busy;
	logic                     valid;
	logic signed [DATA_W-1:0] item;
	logic [4:0]               entry_count;
	logic [1:0]               status;
	logic                     last;

	// Behavioural copy of the list, head at index 0
	logic signed [DATA_W-1:0] list_model[$];
	list_result_t             pending_results[$];
	int                       mismatches = 0;
	int                       cycles     = 0;
	bit                       no_idle    = 1'b0;

	ordered_list_append_remove uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.value      (value),
		.valid      (valid),
		.item       (item),
		.entry_count(entry_count),
		.status     (status),
		.last       (last)
	);

	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
			logic [DATA_W-1:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t ns: %s wrong, got %0h, expected %0h", $time, what, got, want);
	endtask

	function automatic list_result_t make_result(logic signed [DATA_W-1:0] v,
			logic [1:0] st, logic lst);
		list_result_t r;
		r.item        = v;
		r.entry_count = 5'(list_model.size());
		r.status      = st;
		r.last        = lst;
		return r;
	endfunction

	// Update the list copy for one accepted beat and queue the results it gives
	task automatic predict_list_op(logic [1:0] op, logic signed [DATA_W-1:0] v);
		int hit;
		int n;
		hit = -1;
		case (op)
			OP_APPEND: begin
				if (list_model.size() >= DEPTH) begin
					pending_results.push_back(make_result(v, ST_FULL, 1'b1));
				end else begin
					list_model.push_back(v);
					pending_results.push_back(make_result(v, ST_OK, 1'b1));
				end
			end
			OP_REMOVE: begin
				for (int i = 0; i < list_model.size(); i++)
					if (hit < 0 && list_model[i] == v)
						hit = i;
				if (hit >= 0)
					list_model.delete(hit);
				pending_results.push_back(make_result(v,
					(hit >= 0) ? ST_OK : ST_NOT_FOUND, 1'b1));
			end
			OP_DUMP: begin
				n = list_model.size();
				if (n > RESULT_CAP)
					n = RESULT_CAP;
				if (n == 0)
					pending_results.push_back(make_result('0, ST_EMPTY, 1'b1));
				for (int i = 0; i < n; i++)
					pending_results.push_back(make_result(list_model[i], ST_OK, i == n - 1));
			end
			default: ;
		endcase
	endtask

	// Send one command beat; called at a rising edge, returns at the edge that takes it
	task automatic send_command(logic [1:0] op, logic signed [DATA_W-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		opcode <= op;
		value  <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_list_op(op, v);
	endtask

	// Hold off until every queued result has come out
	task automatic wait_for_results();
		start <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
	endtask

	// Result checker: oldest expectation first
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && valid) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result item", item, '0);
			end else begin
				want = pending_results.pop_front();
				if (item !== want.item)
					report_mismatch("item", item, want.item);
				if (entry_count !== want.entry_count)
					report_mismatch("entry_count", entry_count, want.entry_count);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value(bit from_list);
		logic signed [DATA_W-1:0] v;
		int r;
		r = $urandom_range(0, 99);
		if (from_list && list_model.size() > 0 && r < 75)
			return list_model[$urandom_range(0, list_model.size() - 1)];
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = '0;
					default: v = -1;
				endcase
			end
			1, 2, 3: v = $urandom_range(0, 6) - 3;	// small pool, gives duplicates
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Empty list cases, the spare opcode and removal of a lone entry
	task automatic test_empty_list();
		send_command(OP_REMOVE, 5);
		send_command(OP_NONE, 32'sh7fff_ffff);
		send_command(OP_APPEND, 32'sh8000_0000);
		send_command(OP_REMOVE, 32'sh8000_0000);
		send_command(OP_DUMP, 0);
	endtask

	// Fill to capacity with extremes and repeats, overflow, then read back
	task automatic test_fill_to_capacity();
		logic signed [DATA_W-1:0] fill_vals[16] = '{
			32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 7, 7, 1, -2,
			32'sh5555_5555, 32'shaaaa_aaaa, 7, 100, -100, 2, 3, 4};
		for (int i = 0; i < DEPTH; i++)
			send_command(OP_APPEND, fill_vals[i % 16]);
		send_command(OP_APPEND, 9);
		send_command(OP_DUMP, 0);
	endtask

	// First match among repeats, tail, head and a miss, order kept
	task automatic test_remove_order();
		send_command(OP_REMOVE, 7);
		send_command(OP_REMOVE, 4);
		send_command(OP_REMOVE, 32'sh8000_0000);
		send_command(OP_REMOVE, 12345);
		send_command(OP_DUMP, 0);
		wait_for_results();
	endtask

	// Random traffic, swinging the list between empty and full
	task automatic test_random_traffic();
		int sent;
		int roll;
		bit grow;
		sent = 0;
		grow = 1'b1;
		while (sent < RANDOM_BEATS) begin
			if ($urandom_range(0, 15) == 0)
				no_idle = ~no_idle;
			if (list_model.size() == 0)
				grow = 1'b1;
			else if (list_model.size() >= DEPTH && $urandom_range(0, 1))
				grow = 1'b0;
			else if ($urandom_range(0, 39) == 0)
				grow = ~grow;
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				send_command(OP_NONE, $urandom);
			end else begin
				if (roll < 18)
					send_command(OP_DUMP, $urandom);
				else if ((roll < 80) == grow)
					send_command(OP_APPEND, pick_value(1'b0));
				else
					send_command(OP_REMOVE, pick_value(1'b1));
				sent++;
				if (sent % 65 == 0)
					wait_for_results();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_to_capacity();
		test_remove_order();
		test_random_traffic();
		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DEPTH + 4) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
